/* sv/ptsa_pkg.sv */
// shared types, constants and helpers for partition time sync accounting
package ptsa_pkg;

  localparam int NUM_PARTS = 16;
  localparam int PART_W    = $clog2(NUM_PARTS);
  localparam int SIZE_W    = $clog2(NUM_PARTS + 1);
  localparam int ACT_W     = 5;
  localparam int DATA_W    = 32;
  localparam int TOTAL_W   = 36;
  localparam int SUM_W     = DATA_W + PART_W;
  localparam int WIDE_W    = TOTAL_W + 2;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SYNC = 2'd1,
    OP_PROC = 2'd2,
    OP_BUMP = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_SUM,
    ST_MIX,
    ST_FIN
  } state_e;

  // one partition's time record as it travels the ring
  typedef struct packed {
    logic [DATA_W-1:0] elapsed;
    logic [DATA_W-1:0] idle;
  } rec_t;

  typedef struct packed {
    logic              apply;
    logic              tick_hit;
    logic              sync_hit;
    logic [DATA_W-1:0] top;
  } head_cmd_t;

  function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
    return (v == {DATA_W{1'b1}}) ? v : v + DATA_W'(1);
  endfunction

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
  endfunction

endpackage

/* sv/ptsa_in_if.sv */
// request channel carrying one operation
interface ptsa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  partition_index;
  logic [15:0] partition_mask;

  modport source (output valid, operation, partition_index, partition_mask, input ready);
  modport sink   (input valid, operation, partition_index, partition_mask, output ready);
endinterface

/* sv/ptsa_out_if.sv */
// result channel carrying the accounting figures
interface ptsa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] makespan;
  logic [31:0] sync_count;
  logic [31:0] processed_count;
  logic [35:0] total_idle;
  logic [31:0] partition_elapsed;
  logic [31:0] partition_idle;
  logic [31:0] size_histogram_count;

  modport source (output valid, makespan, sync_count, processed_count, total_idle,
                  partition_elapsed, partition_idle, size_histogram_count, input ready);
  modport sink   (input valid, makespan, sync_count, processed_count, total_idle,
                  partition_elapsed, partition_idle, size_histogram_count, output ready);
endinterface

/* sv/ptsa_cell.sv */
// one ring slot holding a partition's elapsed and idle time
module ptsa_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  ptsa_pkg::rec_t rec_i,
  output ptsa_pkg::rec_t rec_o
);
  import ptsa_pkg::*;

  rec_t rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else if (shift_i) begin
      rec_q <= rec_i;
    end
  end

  assign rec_o = rec_q;

endmodule

/* sv/ptsa_head.sv */
// update applied to the record leaving the head of the ring
module ptsa_head (
  input  ptsa_pkg::head_cmd_t cmd_i,
  input  ptsa_pkg::rec_t      rec_i,
  output ptsa_pkg::rec_t      rec_o
);
  import ptsa_pkg::*;

  always_comb begin
    rec_o = rec_i;
    if (cmd_i.apply && cmd_i.tick_hit) begin
      rec_o.elapsed = sat_inc(rec_i.elapsed);
    end
    if (cmd_i.apply && cmd_i.sync_hit) begin
      // top is the set maximum, so the skipped time never wraps
      rec_o.idle    = sat_add(rec_i.idle, cmd_i.top - rec_i.elapsed);
      rec_o.elapsed = cmd_i.top;
    end
  end

endmodule

/* sv/partition_time_sync_accounting.sv */
// top level: partition time sync accounting with a rotating ring of partition cells
//
// usage: one request on req_i (operation, partition_index, partition_mask) gives
// exactly one result on rsp_o, valid/ready on both sides, taken when both are high.
// the 16 partition records sit in a ring of cells that rotates by one each cycle while a
// request is scanned or applied; the head cell feeds an update unit whose output re-enters at the tail.
// a sync turns the ring twice (find the set maximum, then apply it) and then
// passes the sum, mix and finish states; tick, processed and bump requests turn
// it once and then pass the same states. one request is in work at a time and
// the next one is taken only from the idle state, after the last one has left
// the finish state for the output register.
// a finished result waits in the output register while the next request is
// taken; a stalled receiver holds the result and the following request then
// waits in its last cycle until the output register is free.
// the active partition count is written through cfg_we_i/cfg_wdata_i; the user must write it only
// while idle, the block itself does not enforce this. values above 16 act as 16.
// reset clears all times, counters and the histogram, sets the active count to
// 16, and leaves the block ready for a request in the first cycle.
module partition_time_sync_accounting (
  input  logic             clk_i,
  input  logic             rst_ni,
  ptsa_in_if.sink          req_i,
  ptsa_out_if.source       rsp_o,
  input  logic             cfg_we_i,
  input  logic [4:0]       cfg_wdata_i
);
  import ptsa_pkg::*;

  state_e state_q, state_d;

  logic [ACT_W-1:0]     active_q;
  logic [ACT_W-1:0]     n_q;
  op_e                  op_q;
  logic [PART_W-1:0]    idx_q;
  logic [NUM_PARTS-1:0] mask_q;
  logic [PART_W-1:0]    cnt_q;
  logic [DATA_W-1:0]    top_q;
  logic [SIZE_W-1:0]    size_q;
  logic [DATA_W-1:0]    span_q;
  logic [SUM_W-1:0]     sum_idle_q;
  logic [SUM_W-1:0]     sum_el_q;
  logic [DATA_W-1:0]    pe_q;
  logic [DATA_W-1:0]    pidle_q;
  logic [DATA_W-1:0]    pi_sat_q;
  logic [WIDE_W-1:0]    prod_q;
  logic [WIDE_W-1:0]    part_q;
  logic [DATA_W-1:0]    hist_out_q;
  logic [DATA_W-1:0]    sync_q;
  logic [DATA_W-1:0]    proc_q;
  logic [DATA_W-1:0]    hist_q [NUM_PARTS+1];

  logic                 out_valid_q;
  logic [DATA_W-1:0]    o_span_q, o_sync_q, o_proc_q, o_pe_q, o_pi_q, o_hist_q;
  logic [TOTAL_W-1:0]   o_total_q;

  logic                 shift;
  logic                 last;
  logic                 pos_active;
  logic                 idx_active;
  logic                 out_free;
  logic                 req_acc;
  head_cmd_t            cmd;
  rec_t                 ring [NUM_PARTS];
  rec_t                 head_out;
  logic [DATA_W:0]      pi_sum;
  logic [WIDE_W-1:0]    total_wide;

  // ring of cells, cell 0 is the head
  for (genvar k = 0; k < NUM_PARTS; k++) begin : g_cell
    rec_t cell_in;
    if (k == NUM_PARTS - 1) begin : g_tail
      assign cell_in = head_out;
    end else begin : g_mid
      assign cell_in = ring[k+1];
    end
    ptsa_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .rec_i  (cell_in),
      .rec_o  (ring[k])
    );
  end

  ptsa_head u_head (
    .cmd_i(cmd),
    .rec_i(ring[0]),
    .rec_o(head_out)
  );

  assign last       = (cnt_q == PART_W'(NUM_PARTS - 1));
  assign pos_active = ({1'b0, cnt_q} < n_q);
  assign idx_active = ({1'b0, idx_q} < n_q);
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign req_acc    = req_i.valid && req_i.ready;

  assign cmd.apply    = (state_q == ST_APPLY);
  assign cmd.tick_hit = (op_q == OP_TICK) && (cnt_q == idx_q) && pos_active;
  assign cmd.sync_hit = (op_q == OP_SYNC) && mask_q[cnt_q] && pos_active;
  assign cmd.top      = top_q;

  assign pi_sum     = {1'b0, pidle_q} + {1'b0, span_q - pe_q};
  assign total_wide = WIDE_W'(sum_idle_q) + part_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    shift       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = (op_e'(req_i.operation) == OP_SYNC) ? ST_SCAN : ST_APPLY;
        end
      end
      ST_SCAN: begin
        shift = 1'b1;
        if (last) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        shift = 1'b1;
        if (last) state_d = ST_SUM;
      end
      ST_SUM:  state_d = ST_MIX;
      ST_MIX:  state_d = ST_FIN;
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACT_W'(NUM_PARTS);
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // counters and histogram
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q     <= '0;
      proc_q     <= '0;
      hist_out_q <= '0;
      for (int i = 0; i <= NUM_PARTS; i++) begin
        hist_q[i] <= '0;
      end
    end else if (state_q == ST_SUM) begin
      hist_out_q <= '0;
      case (op_q)
        OP_SYNC: begin
          hist_q[size_q] <= sat_inc(hist_q[size_q]);
          hist_out_q     <= sat_inc(hist_q[size_q]);
          if (size_q > SIZE_W'(1)) sync_q <= sat_inc(sync_q);
        end
        OP_PROC: proc_q <= sat_inc(proc_q);
        OP_BUMP: sync_q <= sat_inc(sync_q);
        default: ;
      endcase
    end
  end

  // per-request working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_acc || (shift && last)) begin
      cnt_q <= '0;
    end else if (shift) begin
      cnt_q <= cnt_q + PART_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      op_q       <= op_e'(req_i.operation);
      idx_q      <= req_i.partition_index;
      mask_q     <= req_i.partition_mask;
      n_q        <= (active_q > ACT_W'(NUM_PARTS)) ? ACT_W'(NUM_PARTS) : active_q;
      top_q      <= '0;
      size_q     <= '0;
      span_q     <= '0;
      sum_idle_q <= '0;
      sum_el_q   <= '0;
      pe_q       <= '0;
      pidle_q    <= '0;
    end
    if (state_q == ST_SCAN && mask_q[cnt_q] && pos_active) begin
      size_q <= size_q + SIZE_W'(1);
      if (ring[0].elapsed > top_q) top_q <= ring[0].elapsed;
    end
    if (state_q == ST_APPLY && pos_active) begin
      if (head_out.elapsed > span_q) span_q <= head_out.elapsed;
      sum_idle_q <= sum_idle_q + SUM_W'(head_out.idle);
      sum_el_q   <= sum_el_q + SUM_W'(head_out.elapsed);
      if (cnt_q == idx_q) begin
        pe_q    <= head_out.elapsed;
        pidle_q <= head_out.idle;
      end
    end
    if (state_q == ST_SUM) begin
      prod_q   <= WIDE_W'(n_q) * WIDE_W'(span_q);
      pi_sat_q <= pi_sum[DATA_W] ? {DATA_W{1'b1}} : pi_sum[DATA_W-1:0];
    end
    if (state_q == ST_MIX) begin
      // tail to the makespan summed as n * span minus the elapsed total
      part_q <= prod_q - WIDE_W'(sum_el_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      o_span_q  <= span_q;
      o_sync_q  <= sync_q;
      o_proc_q  <= proc_q;
      o_total_q <= (total_wide > WIDE_W'({TOTAL_W{1'b1}})) ? {TOTAL_W{1'b1}}
                                                          : total_wide[TOTAL_W-1:0];
      o_pe_q    <= idx_active ? pe_q : '0;
      o_pi_q    <= idx_active ? pi_sat_q : '0;
      o_hist_q  <= hist_out_q;
    end
  end

  assign rsp_o.valid                = out_valid_q;
  assign rsp_o.makespan             = o_span_q;
  assign rsp_o.sync_count           = o_sync_q;
  assign rsp_o.processed_count      = o_proc_q;
  assign rsp_o.total_idle           = o_total_q;
  assign rsp_o.partition_elapsed    = o_pe_q;
  assign rsp_o.partition_idle       = o_pi_q;
  assign rsp_o.size_histogram_count = o_hist_q;

endmodule

/* tb/ptsa_tb_pkg.sv */
// scoreboard for partition time sync accounting: predicts and checks each result
`timescale 1ns / 100ps

package ptsa_tb_pkg;
  import ptsa_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0]  makespan;
    logic [DATA_W-1:0]  sync_count;
    logic [DATA_W-1:0]  processed_count;
    logic [TOTAL_W-1:0] total_idle;
    logic [DATA_W-1:0]  partition_elapsed;
    logic [DATA_W-1:0]  partition_idle;
    logic [DATA_W-1:0]  size_histogram_count;
  } acct_result_t;

  class accounting_scoreboard;
    logic [DATA_W-1:0] elapsed   [NUM_PARTS];
    logic [DATA_W-1:0] idle      [NUM_PARTS];
    logic [DATA_W-1:0] size_hist [NUM_PARTS+1];
    logic [DATA_W-1:0] sync_total;
    logic [DATA_W-1:0] processed_total;
    logic [ACT_W-1:0]  active_parts;
    acct_result_t      expected_figures[$];
    int                errors;

    function new();
      foreach (elapsed[i]) begin
        elapsed[i] = '0;
        idle[i]    = '0;
      end
      foreach (size_hist[i]) size_hist[i] = '0;
      sync_total      = '0;
      processed_total = '0;
      active_parts    = ACT_W'(NUM_PARTS);
      errors          = 0;
    endfunction

    function void set_active(logic [ACT_W-1:0] value);
      active_parts = value;
    endfunction

    function int pending();
      return expected_figures.size();
    endfunction

    function logic [DATA_W-1:0] count_up(logic [DATA_W-1:0] v);
      return (v == {DATA_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // apply one accepted request and queue the figures it must produce
    function void note_request(op_e op, logic [PART_W-1:0] idx, logic [NUM_PARTS-1:0] mask);
      acct_result_t      res;
      int                n;
      int                set_size;
      logic [DATA_W-1:0] top;
      logic [DATA_W-1:0] span;
      logic [DATA_W:0]   part_sum;
      logic [63:0]       total;

      n        = (active_parts > NUM_PARTS) ? NUM_PARTS : int'(active_parts);
      res      = '0;
      set_size = 0;
      top      = '0;
      span     = '0;
      total    = '0;

      case (op)
        OP_TICK: begin
          if (idx < n) elapsed[idx] = count_up(elapsed[idx]);
        end
        OP_SYNC: begin
          for (int i = 0; i < n; i++) begin
            if (mask[i]) begin
              set_size++;
              if (elapsed[i] > top) top = elapsed[i];
            end
          end
          for (int i = 0; i < n; i++) begin
            if (mask[i]) begin
              part_sum   = {1'b0, idle[i]} + {1'b0, top - elapsed[i]};
              idle[i]    = part_sum[DATA_W] ? {DATA_W{1'b1}} : part_sum[DATA_W-1:0];
              elapsed[i] = top;
            end
          end
          size_hist[set_size] = count_up(size_hist[set_size]);
          res.size_histogram_count = size_hist[set_size];
          if (set_size > 1) sync_total = count_up(sync_total);
        end
        OP_PROC: begin
          processed_total = count_up(processed_total);
        end
        default: begin
          sync_total = count_up(sync_total);
        end
      endcase

      for (int i = 0; i < n; i++)
        if (elapsed[i] > span) span = elapsed[i];
      for (int i = 0; i < n; i++)
        total += 64'(idle[i]) + 64'(span - elapsed[i]);
      if (total > 64'hF_FFFF_FFFF) total = 64'hF_FFFF_FFFF;

      res.makespan        = span;
      res.sync_count      = sync_total;
      res.processed_count = processed_total;
      res.total_idle      = total[TOTAL_W-1:0];
      if (idx < n) begin
        part_sum = {1'b0, idle[idx]} + {1'b0, span - elapsed[idx]};
        res.partition_elapsed = elapsed[idx];
        res.partition_idle    = part_sum[DATA_W] ? {DATA_W{1'b1}} : part_sum[DATA_W-1:0];
      end
      expected_figures.push_back(res);
    endfunction

    function void compare_field(string name, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(acct_result_t got);
      acct_result_t want;
      if (expected_figures.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      want = expected_figures.pop_front();
      compare_field("makespan", TOTAL_W'(want.makespan), TOTAL_W'(got.makespan));
      compare_field("sync_count", TOTAL_W'(want.sync_count), TOTAL_W'(got.sync_count));
      compare_field("processed_count", TOTAL_W'(want.processed_count),
                    TOTAL_W'(got.processed_count));
      compare_field("total_idle", want.total_idle, got.total_idle);
      compare_field("partition_elapsed", TOTAL_W'(want.partition_elapsed),
                    TOTAL_W'(got.partition_elapsed));
      compare_field("partition_idle", TOTAL_W'(want.partition_idle),
                    TOTAL_W'(got.partition_idle));
      compare_field("size_histogram_count", TOTAL_W'(want.size_histogram_count),
                    TOTAL_W'(got.size_histogram_count));
    endfunction
  endclass

endpackage

/* tb/partition_time_sync_accounting_tb.sv */
// testbench for partition time sync accounting: random requests checked against a predictor
`timescale 1ns / 100ps

module partition_time_sync_accounting_tb;
  import ptsa_pkg::*;
  import ptsa_tb_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int PHASES        = 8;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [ACT_W-1:0] cfg_wdata_i;

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int          cycle_count;

  logic [ACT_W-1:0] phase_active [PHASES] = '{5'd16, 5'd5, 5'd31, 5'd12,
                                              5'd20, 5'd1, 5'd0, 5'd16};
  idle_mode_e       phase_idling [PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                                              IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
  int               phase_items  [PHASES] = '{300, 250, 250, 250, 250, 150, 80, 420};

  accounting_scoreboard sb;
  acct_result_t         seen;

  ptsa_in_if  req_if ();
  ptsa_out_if rsp_if ();

  partition_time_sync_accounting u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver held off during reset
  always @(posedge clk_i) begin
    rsp_if.ready <= rst_ni && ($urandom_range(99) >= receiver_stall_pct);
  end

  // results are checked before the request taken on the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        seen.makespan             = rsp_if.makespan;
        seen.sync_count           = rsp_if.sync_count;
        seen.processed_count      = rsp_if.processed_count;
        seen.total_idle           = rsp_if.total_idle;
        seen.partition_elapsed    = rsp_if.partition_elapsed;
        seen.partition_idle       = rsp_if.partition_idle;
        seen.size_histogram_count = rsp_if.size_histogram_count;
        sb.check_result(seen);
      end
      if (req_if.valid && req_if.ready)
        sb.note_request(op_e'(req_if.operation), req_if.partition_index,
                        req_if.partition_mask);
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      IDLE_SENDER: begin
        sender_idle_pct    = 67;
        receiver_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 67;
      end
      default: begin
        sender_idle_pct    = 29;
        receiver_stall_pct = 29;
      end
    endcase
  endtask

  // valid stays high after acceptance; only an idle gap or settle() drops it
  task automatic send_request(input op_e op, input logic [PART_W-1:0] idx,
                              input logic [NUM_PARTS-1:0] mask);
    if ($urandom_range(99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    req_if.valid           <= 1'b1;
    req_if.operation       <= op;
    req_if.partition_index <= idx;
    req_if.partition_mask  <= mask;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_active(input logic [ACT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_active(value);
  endtask

  initial begin
    int                   pick;
    op_e                  op;
    logic [PART_W-1:0]    idx;
    logic [NUM_PARTS-1:0] mask;

    sb                     = new();
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_wdata_i            = '0;
    req_if.valid           = 1'b0;
    req_if.operation       = OP_TICK;
    req_if.partition_index = '0;
    req_if.partition_mask  = '0;
    set_idling(IDLE_NONE);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset count, empty and full sets, single member, extremes of the index
    send_request(OP_PROC, 4'd0, 16'h0000);
    send_request(OP_BUMP, 4'd15, 16'hFFFF);
    send_request(OP_SYNC, 4'd0, 16'h0000);
    send_request(OP_TICK, 4'd0, 16'h0000);
    send_request(OP_TICK, 4'd0, 16'h0000);
    send_request(OP_TICK, 4'd0, 16'h0000);
    send_request(OP_TICK, 4'd15, 16'h0000);
    send_request(OP_SYNC, 4'd15, 16'h8001);
    send_request(OP_SYNC, 4'd7, 16'hFFFF);
    send_request(OP_TICK, 4'd3, 16'h0000);
    send_request(OP_SYNC, 4'd3, 16'h0008);
    settle();
    // no active partition: ticks dropped, every set empty
    write_active(5'd0);
    send_request(OP_TICK, 4'd0, 16'h0000);
    send_request(OP_SYNC, 4'd0, 16'hFFFF);
    send_request(OP_PROC, 4'd5, 16'h0000);
    send_request(OP_BUMP, 4'd5, 16'h0000);
    settle();
    write_active(5'd31);
    send_request(OP_TICK, 4'd15, 16'h0000);
    send_request(OP_SYNC, 4'd15, 16'hFFFF);
    settle();
    // one partition: mask bit of an inactive one must not count
    write_active(5'd1);
    send_request(OP_TICK, 4'd0, 16'h0000);
    send_request(OP_TICK, 4'd1, 16'h0000);
    send_request(OP_SYNC, 4'd1, 16'h0003);
    settle();
    write_active(5'd16);
    send_request(OP_SYNC, 4'd1, 16'hFFFF);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_active(phase_active[p]);
      set_idling(phase_idling[p]);
      for (int k = 0; k < phase_items[p]; k++) begin
        pick = $urandom_range(99);
        if (pick < 40) op = OP_TICK;
        else if (pick < 70) op = OP_SYNC;
        else if (pick < 85) op = OP_PROC;
        else op = OP_BUMP;
        idx  = PART_W'($urandom_range(NUM_PARTS - 1));
        pick = $urandom_range(99);
        if (pick < 25) mask = NUM_PARTS'($urandom_range(16'hFFFF));
        else if (pick < 75) mask = NUM_PARTS'($urandom & $urandom);
        else if (pick < 90) mask = '1;
        else mask = NUM_PARTS'(1) << $urandom_range(NUM_PARTS - 1);
        send_request(op, idx, mask);
      end
    end
    settle();

    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
sv/ptsa_pkg.sv
sv/ptsa_in_if.sv
sv/ptsa_out_if.sv
sv/ptsa_cell.sv
sv/ptsa_head.sv
sv/partition_time_sync_accounting.sv
tb/ptsa_tb_pkg.sv
tb/partition_time_sync_accounting_tb.sv
